/* src/raal_pkg.sv */
// Shared types and codes for the register access allowlist.
// No dependencies; every other file of the block imports this package.
package raal_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_MISS,
		S_RESP
	} state_t;

	typedef struct packed {
		op_t         kind;
		logic [31:0] reg_address;
		logic [63:0] new_mask;
		logic [7:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] mask_out;
		logic [31:0] address_out;
		status_t     status;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

endpackage

/* src/raal_store.sv */
// Key and mask storage of the allowlist: one write port, one read port,
// read data registered. Depends on raal_pkg for the control struct.
module raal_store #(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  raal_pkg::store_ctl_t   ctl,
	input  logic [AW-1:0]          rd_addr,
	input  logic [AW-1:0]          wr_addr,
	input  logic [KEY_BITS-1:0]    wr_key,
	input  logic [63:0]            wr_mask,
	output logic [KEY_BITS-1:0]    rd_key,
	output logic [63:0]            rd_mask
);
	import raal_pkg::*;

	logic [KEY_BITS-1:0] key_mem [DEPTH];
	logic [63:0]         mask_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			mask_mem[wr_addr] <= wr_mask;
		end
		if (ctl.rd_en) begin
			rd_key  <= key_mem[rd_addr];
			rd_mask <= mask_mem[rd_addr];
		end
	end

endmodule

/* src/register_access_allowlist.sv */
// Top level of the register access allowlist: handshake, scan sequencer, result register.
// Depends on raal_pkg and raal_store.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | raal_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall | raal_pkg::rsp_t
//
// Clear goes to S_RESP; read by index through S_READ, S_CHECK and S_RESP (straight to
// S_RESP when out of range). Insert and lookup scan the stored entries through the single
// memory read port, S_READ then S_CHECK per entry; the scan stops at the first match.
// Reset empties the table at once (entry count to zero); no clearing pass.
// A result pending in the output register keeps the next in S_RESP; requests stall.
module register_access_allowlist #(
	parameter int TABLE_ENTRIES = 64,
	parameter int ADDRESS_BITS  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  raal_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output raal_pkg::rsp_t  rsp
);
	import raal_pkg::*;

	localparam int AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW   = $clog2(TABLE_ENTRIES + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;

	state_t                  state_q, state_d;
	op_t                     op_q;
	logic [ADDRESS_BITS-1:0] key_q;
	logic [63:0]             mask_q;
	logic [CW-1:0]           ptr_q;
	logic [CW-1:0]           count_q;
	rsp_t                    res_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;

	store_ctl_t              ctl;
	logic [ADDRESS_BITS-1:0] rd_key;
	logic [63:0]             rd_mask;

	logic req_fire, idx_ok, is_last, is_match, is_full, rsp_load;

	assign req_fire = req_valid && !req_stall;
	assign idx_ok   = CMPW'(req.entry_index) < CMPW'(count_q);
	assign is_last  = CW'(ptr_q + 1'b1) == count_q;
	assign is_match = rd_key == key_q;
	assign is_full  = count_q == CW'(TABLE_ENTRIES);
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	raal_store #(
		.DEPTH    (TABLE_ENTRIES),
		.KEY_BITS (ADDRESS_BITS)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_addr (ptr_q[AW-1:0]),
		.wr_addr (count_q[AW-1:0]),
		.wr_key  (key_q),
		.wr_mask (mask_q),
		.rd_key  (rd_key),
		.rd_mask (rd_mask)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (req.kind)
						OP_CLEAR: state_d = S_RESP;
						OP_READ:  state_d = idx_ok ? S_READ : S_RESP;
						default:  state_d = (count_q == '0) ? S_MISS : S_READ;
					endcase
				end
			end
			S_READ:  state_d = S_CHECK;
			S_CHECK: begin
				if (op_q == OP_READ || is_match) begin
					state_d = S_RESP;
				end else if (is_last) begin
					state_d = S_MISS;
				end else begin
					state_d = S_READ;
				end
			end
			S_MISS:  state_d = S_RESP;
			S_RESP:  state_d = rsp_load ? S_IDLE : S_RESP;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall = state_q != S_IDLE;
		ctl.rd_en = state_q == S_READ;
		ctl.wr_en = (state_q == S_MISS) && (op_q == OP_INSERT) && !is_full;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE && req_fire && req.kind == OP_CLEAR) begin
				count_q <= '0;
			end
			if (state_q == S_CHECK && op_q == OP_INSERT && is_match) begin
				count_q <= '0;
			end
			if (ctl.wr_en) begin
				count_q <= CW'(count_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					op_q   <= req.kind;
					key_q  <= ADDRESS_BITS'(req.reg_address);
					mask_q <= req.new_mask;
					ptr_q  <= (req.kind == OP_READ) ? CW'(req.entry_index) : '0;
					res_q.found       <= 1'b0;
					res_q.mask_out    <= '0;
					res_q.address_out <= '0;
					res_q.status      <= (req.kind == OP_READ && !idx_ok) ? ST_RANGE : ST_OK;
				end
			end
			S_CHECK: begin
				if (op_q == OP_READ) begin
					res_q.found       <= 1'b1;
					res_q.mask_out    <= rd_mask;
					res_q.address_out <= 32'(rd_key);
				end else if (is_match) begin
					if (op_q == OP_LOOKUP) begin
						res_q.found    <= 1'b1;
						res_q.mask_out <= rd_mask;
					end else begin
						res_q.status <= ST_DUP;
					end
				end else begin
					ptr_q <= CW'(ptr_q + 1'b1);
				end
			end
			S_MISS: begin
				if (op_q == OP_INSERT && is_full) begin
					res_q.status <= ST_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count beyond capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> req_stall)
		else $error("accepted transaction did not make the block busy");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("table write without count advance");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> ptr_q < count_q)
		else $error("scan pointer past stored entries");

endmodule
